FILE: rtl/sae_pkg.sv
// Shared widths, operation codes and types for the static-model arithmetic encoder.
package sae_pkg;

  localparam int CODE_W          = 64;
  localparam int TOTAL_W         = 32;
  localparam int SYM_W           = 8;
  localparam int OP_W            = 2;
  localparam int BYTE_W          = 8;
  localparam int NUM_SYMBOLS_DEF = 256;
  // Wide enough for the largest table depth plus one.
  localparam int SYM_CMP_W       = 13;
  localparam int MAX_BYTES       = 8;
  localparam int BYTE_CNT_W      = $clog2(MAX_BYTES + 1);
  localparam int DIGIT_W         = 2;
  localparam int DIV_STEPS       = CODE_W / DIGIT_W;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
  localparam int MUL_STEPS       = TOTAL_W / DIGIT_W;
  localparam int MUL_CNT_W       = $clog2(MUL_STEPS);

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] high;
    logic [CODE_W-1:0] low;
  } interval_t;

endpackage

FILE: rtl/static_model_arithmetic_encoder.sv
// Top level of the static-model arithmetic encoder: control, interval registers, output stage.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_stall   in_opcode, in_symbol, in_cum_value
//   out_      output     out_valid / out_stall out_byte, out_last
//   cfg_      input      cfg_wr_en             cfg_wr_data (total count)
//
// A load request is written into the table as it is accepted and leaves the block idle;
// a finish request waits in the flush state while out_stall keeps the output slot full.
// An encode request fetches both bounds, waits for the radix-4 divider, runs the radix-4
// multiplier and renormalises, releasing up to 8 bytes, slower under out_stall.
// Reset (rst_n low, synchronous) sets the interval to [0, all ones] and the total to 1;
// the table keeps whatever it held and must be loaded before use.
// in_stall is high whenever a request is in progress; results wait in the output register.

module static_model_arithmetic_encoder #(
  parameter int NUM_SYMBOLS = sae_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sae_pkg::OP_W-1:0]     in_opcode,
  input  logic [sae_pkg::SYM_W-1:0]    in_symbol,
  input  logic [sae_pkg::TOTAL_W-1:0]  in_cum_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sae_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_last,
  input  logic                         cfg_wr_en,
  input  logic [sae_pkg::TOTAL_W-1:0]  cfg_wr_data
);
  import sae_pkg::*;

  localparam int IDX_W = $clog2(NUM_SYMBOLS);
  localparam logic [SYM_CMP_W-1:0] NSYM_C = SYM_CMP_W'(NUM_SYMBOLS);

  // Controller states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_LOW = 3'd1;
  localparam logic [2:0] S_RD_UP  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_RENORM = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [CODE_W-1:0]     low_r, low_nxt;
  logic [CODE_W-1:0]     high_r, high_nxt;
  logic [TOTAL_W-1:0]    total_r, total_nxt;
  logic [SYM_W-1:0]      sym_r, sym_nxt;
  logic [TOTAL_W-1:0]    lower_r, lower_nxt;
  logic [TOTAL_W-1:0]    upper_r, upper_nxt;
  logic [BYTE_CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept;
  logic                  sym_in_ok;
  logic                  do_load;
  logic                  do_enc;
  logic                  do_fin;
  logic [SYM_CMP_W-1:0]  sym_up_ext;
  logic                  up_is_total;
  logic                  tbl_rd_en;
  logic [IDX_W-1:0]      tbl_rd_addr;
  logic [TOTAL_W-1:0]    tbl_rd_data;
  logic                  div_busy;
  logic [CODE_W-1:0]     div_q;
  logic                  mul_start;
  logic                  mul_busy;
  interval_t             mul_res;
  logic                  top_eq;
  logic                  cnt_full;
  logic                  slot_free;
  logic                  out_load;

  // The engine takes one request at a time; a new one is accepted only when idle.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Symbols at or beyond the table depth are dropped for both load and encode.
  assign sym_in_ok = SYM_CMP_W'(in_symbol) < NSYM_C;
  assign do_load   = accept && (in_opcode == OP_LOAD) && sym_in_ok;
  assign do_enc    = accept && (in_opcode == OP_ENCODE) && sym_in_ok;
  assign do_fin    = accept && (in_opcode == OP_FINISH);

  // The last symbol's upper bound is the total count rather than a table entry.
  assign sym_up_ext  = SYM_CMP_W'(sym_r) + SYM_CMP_W'(1);
  assign up_is_total = !(sym_up_ext < NSYM_C);

  // The lower bound is read on the accepting edge, the upper bound on the next edge, from S_RD_LOW.
  assign tbl_rd_en   = do_enc || ((state_r == S_RD_LOW) && !up_is_total);
  assign tbl_rd_addr = do_enc ? IDX_W'(in_symbol) : sym_up_ext[IDX_W-1:0];

  sae_cum_table #(
    .DEPTH (NUM_SYMBOLS)
  ) u_table (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_addr (IDX_W'(in_symbol)),
    .wr_data (in_cum_value),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  // The divider starts on the accepting edge and runs while the bounds are fetched.
  sae_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (do_enc),
    .dividend (high_r - low_r),
    .divisor  (total_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign mul_start = (state_r == S_DIV) && !div_busy;

  sae_multiplier u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .q      (div_q),
    .base   (low_r),
    .upper  (upper_r),
    .lower  (lower_r),
    .busy   (mul_busy),
    .result (mul_res)
  );

  // Renormalisation continues while the top bytes of low and high agree,
  // up to the per-symbol cap, and only as fast as the output drains.
  assign top_eq    = (high_r[CODE_W-1 -: BYTE_W] == low_r[CODE_W-1 -: BYTE_W]);
  assign cnt_full  = (byte_cnt_r == BYTE_CNT_W'(MAX_BYTES));
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    total_nxt    = total_r;
    sym_nxt      = sym_r;
    lower_nxt    = lower_r;
    upper_nxt    = upper_r;
    byte_cnt_nxt = byte_cnt_r;
    out_load     = 1'b0;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;

    if (cfg_wr_en) begin
      total_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (do_enc) begin
          sym_nxt   = in_symbol;
          state_nxt = S_RD_LOW;
        end else if (do_fin) begin
          state_nxt = S_FLUSH;
        end
      end
      S_RD_LOW: begin
        lower_nxt = tbl_rd_data;
        state_nxt = S_RD_UP;
      end
      S_RD_UP: begin
        upper_nxt = up_is_total ? total_r : tbl_rd_data;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (!mul_busy) begin
          low_nxt      = mul_res.low;
          high_nxt     = mul_res.high;
          byte_cnt_nxt = '0;
          state_nxt    = S_RENORM;
        end
      end
      S_RENORM: begin
        if (cnt_full || !top_eq) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_load     = 1'b1;
          out_byte_nxt = high_r[CODE_W-1 -: BYTE_W];
          out_last_nxt = 1'b0;
          high_nxt     = high_r << BYTE_W;
          low_nxt      = low_r << BYTE_W;
          byte_cnt_nxt = byte_cnt_r + BYTE_CNT_W'(1);
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_byte_nxt = high_r[CODE_W-1 -: BYTE_W];
          out_last_nxt = 1'b1;
          low_nxt      = '0;
          high_nxt     = '1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_r       <= '0;
      high_r      <= '1;
      total_r     <= TOTAL_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    lower_r    <= lower_nxt;
    upper_r    <= upper_nxt;
    byte_cnt_r <= byte_cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // The renormalisation counter never passes the per-symbol cap.
  a_byte_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RENORM) |-> (byte_cnt_r <= BYTE_CNT_W'(MAX_BYTES)))
    else $error("renormalisation byte count beyond cap");

  // The multiplier only ever sees a settled quotient.
  a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> !div_busy)
    else $error("multiplier running while divider busy");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("output register overwritten while stalled");

  // The final byte of a message leaves the interval at its reset value.
  a_flush_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> ((low_r == '0) && (high_r == '1)))
    else $error("interval not restored after finish");

endmodule

FILE: rtl/sae_cum_table.sv
// Cumulative-count table: one write port and one registered read port.
module sae_cum_table #(
  parameter int DEPTH = sae_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [sae_pkg::TOTAL_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [sae_pkg::TOTAL_W-1:0]  rd_data
);
  import sae_pkg::*;

  logic [TOTAL_W-1:0] mem [DEPTH];
  logic [TOTAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/sae_divider.sv
// Radix-4 restoring divider: 64-bit dividend by 32-bit divisor, two quotient bits a cycle.
module sae_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sae_pkg::CODE_W-1:0]   dividend,
  input  logic [sae_pkg::TOTAL_W-1:0]  divisor,
  output logic                         busy,
  output logic [sae_pkg::CODE_W-1:0]   quotient
);
  import sae_pkg::*;

  localparam int T_W = TOTAL_W + DIGIT_W;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CODE_W-1:0]    dvd_r, dvd_nxt;
  logic [CODE_W-1:0]    quo_r, quo_nxt;
  logic [TOTAL_W-1:0]   rem_r, rem_nxt;
  logic [T_W-1:0]       d1_r, d1_nxt;
  logic [T_W-1:0]       d2_r, d2_nxt;
  logic [T_W-1:0]       d3_r, d3_nxt;
  logic [T_W-1:0]       trial;
  logic [T_W-1:0]       diff;
  logic [DIGIT_W-1:0]   digit;

  // A zero divisor makes every trial succeed, so the quotient comes out all ones.
  always_comb begin
    trial = {rem_r, dvd_r[CODE_W-1 -: DIGIT_W]};
    if (trial >= d3_r) begin
      digit = 2'd3;
      diff  = trial - d3_r;
    end else if (trial >= d2_r) begin
      digit = 2'd2;
      diff  = trial - d2_r;
    end else if (trial >= d1_r) begin
      digit = 2'd1;
      diff  = trial - d1_r;
    end else begin
      digit = 2'd0;
      diff  = trial;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    d3_nxt   = d3_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      d1_nxt   = T_W'(divisor);
      d2_nxt   = T_W'(divisor) << 1;
      d3_nxt   = T_W'(divisor) + (T_W'(divisor) << 1);
    end else if (busy_r) begin
      dvd_nxt = dvd_r << DIGIT_W;
      quo_nxt = {quo_r[CODE_W-DIGIT_W-1:0], digit};
      rem_nxt = diff[TOTAL_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    d1_r  <= d1_nxt;
    d2_r  <= d2_nxt;
    d3_r  <= d3_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/sae_multiplier.sv
// Dual radix-4 shift-and-add unit: base + q * upper and base + q * lower, modulo 2^64.
module sae_multiplier (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sae_pkg::CODE_W-1:0]   q,
  input  logic [sae_pkg::CODE_W-1:0]   base,
  input  logic [sae_pkg::TOTAL_W-1:0]  upper,
  input  logic [sae_pkg::TOTAL_W-1:0]  lower,
  output logic                         busy,
  output sae_pkg::interval_t           result
);
  import sae_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CODE_W-1:0]    mc_r, mc_nxt;
  logic [CODE_W-1:0]    mc3_r, mc3_nxt;
  logic [TOTAL_W-1:0]   mp_hi_r, mp_hi_nxt;
  logic [TOTAL_W-1:0]   mp_lo_r, mp_lo_nxt;
  logic [CODE_W-1:0]    acc_hi_r, acc_hi_nxt;
  logic [CODE_W-1:0]    acc_lo_r, acc_lo_nxt;

  function automatic logic [CODE_W-1:0] pick(input logic [DIGIT_W-1:0] dg,
                                             input logic [CODE_W-1:0] m1,
                                             input logic [CODE_W-1:0] m3);
    logic [CODE_W-1:0] r;
    case (dg)
      2'd0:    r = '0;
      2'd1:    r = m1;
      2'd2:    r = m1 << 1;
      default: r = m3;
    endcase
    return r;
  endfunction

  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    mc_nxt     = mc_r;
    mc3_nxt    = mc3_r;
    mp_hi_nxt  = mp_hi_r;
    mp_lo_nxt  = mp_lo_r;
    acc_hi_nxt = acc_hi_r;
    acc_lo_nxt = acc_lo_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = MUL_CNT_W'(MUL_STEPS - 1);
      mc_nxt     = q;
      mc3_nxt    = q + (q << 1);
      mp_hi_nxt  = upper;
      mp_lo_nxt  = lower;
      acc_hi_nxt = base;
      acc_lo_nxt = base;
    end else if (busy_r) begin
      acc_hi_nxt = acc_hi_r + pick(mp_hi_r[DIGIT_W-1:0], mc_r, mc3_r);
      acc_lo_nxt = acc_lo_r + pick(mp_lo_r[DIGIT_W-1:0], mc_r, mc3_r);
      mp_hi_nxt  = mp_hi_r >> DIGIT_W;
      mp_lo_nxt  = mp_lo_r >> DIGIT_W;
      mc_nxt     = mc_r << DIGIT_W;
      mc3_nxt    = mc3_r << DIGIT_W;
      cnt_nxt    = cnt_r - MUL_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    mc_r     <= mc_nxt;
    mc3_r    <= mc3_nxt;
    mp_hi_r  <= mp_hi_nxt;
    mp_lo_r  <= mp_lo_nxt;
    acc_hi_r <= acc_hi_nxt;
    acc_lo_r <= acc_lo_nxt;
  end

  assign busy        = busy_r;
  assign result.high = acc_hi_r;
  assign result.low  = acc_lo_r;

endmodule

FILE: sim/sae_byte_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the encoder's code bytes and compares them with the output channel.
module sae_byte_checker #(
  parameter int NUM_SYMBOLS = sae_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [sae_pkg::OP_W-1:0]     in_opcode,
  input  logic [sae_pkg::SYM_W-1:0]    in_symbol,
  input  logic [sae_pkg::TOTAL_W-1:0]  in_cum_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [sae_pkg::BYTE_W-1:0]   out_byte,
  input  logic                         out_last,
  input  logic                         cfg_wr_en,
  input  logic [sae_pkg::TOTAL_W-1:0]  cfg_wr_data,
  output int unsigned                  mismatches,
  output int unsigned                  bytes_owed
);

  import sae_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              last;
  } code_byte_t;

  // Top bytes of low and high agree when their XOR fits below this mask.
  localparam logic [CODE_W-1:0] TOP_AGREE = 64'h00FF_FFFF_FFFF_FFFF;

  logic [TOTAL_W-1:0] total;
  logic [CODE_W-1:0]  low;
  logic [CODE_W-1:0]  high;
  logic [TOTAL_W-1:0] bounds [NUM_SYMBOLS];
  code_byte_t         owed [$];
  int unsigned        errors = 0;

  initial begin
    mismatches = 0;
    bytes_owed = 0;
  end

  // Narrows the interval for one symbol and queues the bytes that renormalisation releases.
  task automatic narrow_interval(input logic [SYM_W-1:0] sym);
    logic [CODE_W-1:0] span;
    logic [CODE_W-1:0] quot;
    logic [CODE_W-1:0] lo_bound;
    logic [CODE_W-1:0] hi_bound;
    int unsigned       n;
    span = high - low;
    quot = (total != '0) ? span / CODE_W'(total) : '1;
    lo_bound = CODE_W'(bounds[sym]);
    hi_bound = (int'(sym) + 1 < NUM_SYMBOLS) ? CODE_W'(bounds[SYM_W'(int'(sym) + 1)])
                                             : CODE_W'(total);
    high = low + quot * hi_bound;
    low = low + quot * lo_bound;
    n = 0;
    while (n < MAX_BYTES && (high ^ low) <= TOP_AGREE) begin
      owed.push_back('{code: high[CODE_W-1 -: BYTE_W], last: 1'b0});
      high = high << BYTE_W;
      low = low << BYTE_W;
      n++;
    end
  endtask

  always @(posedge clk) begin : watch
    code_byte_t got;
    code_byte_t want;
    if (!rst_n) begin
      total = TOTAL_W'(1);
      low = '0;
      high = '1;
      owed.delete();
    end else begin
      // Bytes leaving now belong to earlier requests, so they are checked first.
      if (out_valid && !out_stall) begin
        got = '{code: out_byte, last: out_last};
        if (owed.size() == 0) begin
          errors++;
          $display("%0t: expected no byte, got out_byte %h out_last %b",
                   $time, got.code, got.last);
        end else begin
          want = owed.pop_front();
          if (got.code !== want.code) begin
            errors++;
            $display("%0t: out_byte expected %h, got %h", $time, want.code, got.code);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: out_last expected %b, got %b", $time, want.last, got.last);
          end
        end
      end
      if (cfg_wr_en) begin
        total = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        case (in_opcode)
          OP_LOAD: begin
            if (int'(in_symbol) < NUM_SYMBOLS) bounds[in_symbol] = in_cum_value;
          end
          OP_ENCODE: begin
            if (int'(in_symbol) < NUM_SYMBOLS) narrow_interval(in_symbol);
          end
          OP_FINISH: begin
            owed.push_back('{code: high[CODE_W-1 -: BYTE_W], last: 1'b1});
            low = '0;
            high = '1;
          end
          default: begin
          end
        endcase
      end
    end
    mismatches <= errors;
    bytes_owed <= owed.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Top of the encoder testbench: clock, reset, request stimulus, output stalls and verdict.
module tb;

  import sae_pkg::*;

  // The block ignores this operation code; it is sent as noise.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES    = 9;
  // An encode request that releases no byte still keeps the block busy through the divider
  // and the multiplier, so this pause must pass before the total count is rewritten.
  localparam int PAUSE_CYCLES    = 80;
  localparam int STALL_HOLD      = 300;
  localparam int IDLE_LIMIT      = 5000;
  localparam int RANDOM_PHASES   = 5;
  localparam int MIXED_PER_PHASE = 12;
  localparam int MAX_WINDOW      = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode = OP_LOAD;
  logic [SYM_W-1:0]     in_symbol = '0;
  logic [TOTAL_W-1:0]   in_cum_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_last;
  logic                 cfg_wr_en = 1'b0;
  logic [TOTAL_W-1:0]   cfg_wr_data = '0;

  int unsigned mismatches;
  int unsigned bytes_owed;
  int unsigned quiet_cycles = 0;

  // Which table entries have been loaded, so that no encode reads an unwritten one.
  bit loaded [NUM_SYMBOLS_DEF];
  // When set, the sender offers requests back to back without gaps.
  bit steady = 1'b0;
  // Raised by the stimulus to ask the receiver for one long hold; the receiver clears it.
  bit pressure_req = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  static_model_arithmetic_encoder uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_symbol    (in_symbol),
    .in_cum_value (in_cum_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  sae_byte_checker bytes_chk (.*);

  // The watchdog counts cycles in which no request, no byte and no register write moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  // Sender gaps: most requests follow at once or after a few cycles, a few after a long wait.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A symbol may be encoded once both its lower bound and the entry above it are loaded;
  // the last symbol takes its upper bound from the total count instead.
  function automatic bit readable(int unsigned s);
    return loaded[SYM_W'(s)] && (s + 1 == NUM_SYMBOLS_DEF || loaded[SYM_W'(s + 1)]);
  endfunction

  // Offers one request and returns at the edge that accepts it, then idles for a random gap.
  // With no gap, the next call raises the next request in the same step without lowering
  // valid first.
  task automatic send(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                      input logic [TOTAL_W-1:0] val);
    int unsigned g;
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_symbol    <= sym;
    in_cum_value <= val;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (op == OP_LOAD) loaded[sym] = 1'b1;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Waits until every predicted byte has arrived and the block has finished any request
  // that releases nothing, so that the total count may be changed safely.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (bytes_owed == 0);
    repeat (PAUSE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(input logic [TOTAL_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // The receiver alternates between accepting and stalling in runs of random length,
  // with the occasional long accepting stretch, and holds off once for a long time
  // when the stimulus asks for it, so that the block backs up and stalls its input.
  initial begin : receiver
    int unsigned r;
    int unsigned len;
    @(posedge clk);
    forever begin
      if (pressure_req) begin
        out_stall <= 1'b1;
        repeat (STALL_HOLD) @(posedge clk);
        pressure_req = 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 50) begin
          out_stall <= 1'b0;
          len = (r < 8) ? $urandom_range(30, 80) : $urandom_range(1, 8);
        end else begin
          out_stall <= 1'b1;
          len = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [TOTAL_W-1:0] cum_at [MAX_WINDOW + 1];
    logic [TOTAL_W-1:0] cum;
    logic [TOTAL_W-1:0] fmax;
    logic [TOTAL_W-1:0] freq;
    int unsigned        win_base;
    int unsigned        win_len;
    int unsigned        phase;
    int unsigned        i;
    int unsigned        k;
    int unsigned        s;
    int unsigned        r;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With the total at its reset value of one, a single symbol spans the
    // whole range, so nothing is released; the unused operation must be ignored, and the
    // finish releases the top byte of high marked as the last one.
    send(OP_LOAD, 8'd0, 32'd0);
    send(OP_LOAD, 8'd1, 32'd1);
    send(OP_ENCODE, 8'd0, 32'd0);
    send(OP_UNUSED, 8'hAA, 32'h5555_5555);
    send(OP_FINISH, 8'd0, 32'd0);
    drain();

    // Largest total. The last symbol takes its upper bound from the total count and has a
    // frequency of one, which releases three bytes. Symbol 2 has equal bounds, so its
    // interval collapses and renormalisation stops at the cap of eight bytes with low and
    // high still agreeing; the second encode then releases eight more bytes of the collapsed interval.
    write_total(32'hFFFF_FFFF);
    send(OP_LOAD, 8'd255, 32'hFFFF_FFFE);
    send(OP_ENCODE, 8'd255, 32'd0);
    send(OP_LOAD, 8'd2, 32'hFFFF_FFFF);
    send(OP_LOAD, 8'd3, 32'hFFFF_FFFF);
    send(OP_ENCODE, 8'd2, 32'd0);
    send(OP_ENCODE, 8'd2, 32'hFFFF_FFFF);
    send(OP_FINISH, 8'hFF, 32'hFFFF_FFFF);
    send(OP_LOAD, 8'd128, 32'h8000_0000);
    send(OP_LOAD, 8'd129, 32'hC000_0000);
    send(OP_ENCODE, 8'd128, 32'd0);
    send(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    drain();

    // A zero total makes the quotient all ones, and the interval wraps.
    write_total('0);
    send(OP_ENCODE, 8'd128, 32'd0);
    send(OP_ENCODE, 8'd255, 32'd0);
    send(OP_FINISH, 8'd0, 32'd0);
    drain();

    // Random phases. Each builds a well-formed cumulative table over a small window of
    // symbols, sets the total to match, and then sends mostly encodes of those symbols,
    // mixed with finishes, ignored operations and loads of random entries. Frequencies
    // grow from phase to phase, so totals range from a handful to hundreds of millions.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      fmax = 32'd4 << (6 * phase);
      win_len = $urandom_range(2, MAX_WINDOW);
      if ($urandom_range(3) == 0) begin
        win_base = NUM_SYMBOLS_DEF - win_len;
      end else begin
        win_base = $urandom_range(NUM_SYMBOLS_DEF - win_len - 1);
      end
      cum = '0;
      for (i = 0; i <= win_len; i++) begin
        cum_at[i] = cum;
        if (i < win_len) begin
          // Now and then a symbol of zero frequency collapses the interval.
          freq = ($urandom_range(19) == 0) ? '0 : $urandom_range(1, fmax);
          cum = cum + freq;
        end
      end
      write_total(cum);
      steady = (phase == 3);
      pressure_req = (phase == 2);

      for (i = 0; i < win_len; i++) begin
        send(OP_LOAD, SYM_W'(win_base + i), cum_at[i]);
      end
      if (win_base + win_len < NUM_SYMBOLS_DEF) begin
        send(OP_LOAD, SYM_W'(win_base + win_len), cum_at[win_len]);
      end

      for (i = 0; i < MIXED_PER_PHASE; i++) begin
        r = $urandom_range(99);
        if (r < 70) begin
          send(OP_ENCODE, SYM_W'(win_base + $urandom_range(win_len - 1)), $urandom);
        end else if (r < 78) begin
          // Any symbol whose bounds are loaded, including ones overwritten by noise.
          s = $urandom_range(NUM_SYMBOLS_DEF - 1);
          k = 0;
          while (!readable(s) && k < 64) begin
            s = $urandom_range(NUM_SYMBOLS_DEF - 1);
            k++;
          end
          if (!readable(s)) s = win_base;
          send(OP_ENCODE, SYM_W'(s), $urandom);
        end else if (r < 84) begin
          send(OP_FINISH, SYM_W'($urandom), $urandom);
        end else if (r < 90) begin
          send(OP_UNUSED, SYM_W'($urandom), $urandom);
        end else begin
          send(OP_LOAD, SYM_W'($urandom), $urandom);
        end
      end
      send(OP_FINISH, SYM_W'($urandom), $urandom);
      drain();
    end
    steady = 1'b0;

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
